// ----- sv/tfd_pkg.sv -----
// tfd_pkg: shared types and constants for the telemetry frame deframer
// no dependencies; used by every module of the block but tfd_checker

package tfd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned VALUE_W  = 16;
    localparam int unsigned COUNT_W  = 3;
    localparam int unsigned PADDR_W  = 5;
    localparam int unsigned PDATA_W  = 32;

    localparam logic [COUNT_W-1:0] SERVO_PAYLOAD = 3'd4;
    localparam logic [COUNT_W-1:0] SHORT_PAYLOAD = 3'd2;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_START    = 3'd0;
    localparam logic [2:0] REG_END      = 3'd1;
    localparam logic [2:0] REG_SERVO    = 3'd2;
    localparam logic [2:0] REG_BATTERY  = 3'd3;
    localparam logic [2:0] REG_VELOCITY = 3'd4;

    localparam logic [BYTE_W-1:0] RST_START    = 8'd2;
    localparam logic [BYTE_W-1:0] RST_END      = 8'd3;
    localparam logic [BYTE_W-1:0] RST_SERVO    = 8'd16;
    localparam logic [BYTE_W-1:0] RST_BATTERY  = 8'd17;
    localparam logic [BYTE_W-1:0] RST_VELOCITY = 8'd18;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_TYPE     = 3'd1,
        PH_SERVO    = 3'd2,
        PH_BATTERY  = 3'd3,
        PH_VELOCITY = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        KIND_SERVO    = 2'd0,
        KIND_BATTERY  = 2'd1,
        KIND_VELOCITY = 2'd2
    } t_kind;

    typedef struct packed {
        logic [BYTE_W-1:0] start_byte;
        logic [BYTE_W-1:0] end_byte;
        logic [BYTE_W-1:0] servo_type;
        logic [BYTE_W-1:0] battery_type;
        logic [BYTE_W-1:0] velocity_type;
    } t_cfg;

    typedef struct packed {
        t_kind              kind;
        logic [VALUE_W-1:0] first_value;
        logic [VALUE_W-1:0] second_value;
    } t_result;

endpackage

// ----- sv/tfd_cfg_regs.sv -----
// tfd_cfg_regs: apb register file holding the frame marker bytes
// depends on tfd_pkg

module tfd_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tfd_pkg::PADDR_W-1:0]   paddr,
    input  logic [tfd_pkg::PDATA_W-1:0]   pwdata,
    output logic [tfd_pkg::PDATA_W-1:0]   prdata,
    output tfd_pkg::t_cfg                 o_cfg
);

    tfd_pkg::t_cfg r_cfg;
    logic          w_wr;
    logic [2:0]    w_idx;
    logic [tfd_pkg::BYTE_W-1:0] w_rd_byte;

    assign w_wr  = psel && penable && pwrite;
    assign w_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte    <= tfd_pkg::RST_START;
            r_cfg.end_byte      <= tfd_pkg::RST_END;
            r_cfg.servo_type    <= tfd_pkg::RST_SERVO;
            r_cfg.battery_type  <= tfd_pkg::RST_BATTERY;
            r_cfg.velocity_type <= tfd_pkg::RST_VELOCITY;
        end else if (w_wr) begin
            unique case (w_idx)
                tfd_pkg::REG_START:    r_cfg.start_byte    <= pwdata[7:0];
                tfd_pkg::REG_END:      r_cfg.end_byte      <= pwdata[7:0];
                tfd_pkg::REG_SERVO:    r_cfg.servo_type    <= pwdata[7:0];
                tfd_pkg::REG_BATTERY:  r_cfg.battery_type  <= pwdata[7:0];
                tfd_pkg::REG_VELOCITY: r_cfg.velocity_type <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            tfd_pkg::REG_START:    w_rd_byte = r_cfg.start_byte;
            tfd_pkg::REG_END:      w_rd_byte = r_cfg.end_byte;
            tfd_pkg::REG_SERVO:    w_rd_byte = r_cfg.servo_type;
            tfd_pkg::REG_BATTERY:  w_rd_byte = r_cfg.battery_type;
            tfd_pkg::REG_VELOCITY: w_rd_byte = r_cfg.velocity_type;
            default:               w_rd_byte = '0;
        endcase
    end

    assign prdata = {{(tfd_pkg::PDATA_W - tfd_pkg::BYTE_W){1'b0}}, w_rd_byte};
    assign o_cfg  = r_cfg;

endmodule

// ----- sv/tfd_parser.sv -----
// tfd_parser: frame state machine and payload buffer, one byte per step
// depends on tfd_pkg

module tfd_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [tfd_pkg::BYTE_W-1:0]  i_byte,
    input  tfd_pkg::t_cfg               i_cfg,
    output logic                        o_hit,
    output tfd_pkg::t_result            o_result
);

    tfd_pkg::t_phase               r_phase, n_phase;
    logic [tfd_pkg::COUNT_W-1:0]   r_count, n_count;
    logic [tfd_pkg::BYTE_W-1:0]    r_payload [4];
    logic                          w_store;
    logic                          w_in_payload;
    logic [tfd_pkg::COUNT_W-1:0]   w_need;

    assign w_need = (r_phase == tfd_pkg::PH_SERVO) ? tfd_pkg::SERVO_PAYLOAD
                                                   : tfd_pkg::SHORT_PAYLOAD;

    // next state
    always_comb begin
        n_phase      = r_phase;
        n_count      = r_count;
        w_store      = 1'b0;
        w_in_payload = 1'b0;
        unique case (r_phase)
            tfd_pkg::PH_IDLE: begin
                n_count = '0;
                if (i_byte == i_cfg.start_byte) begin
                    n_phase = tfd_pkg::PH_TYPE;
                end
            end
            tfd_pkg::PH_TYPE: begin
                n_count = '0;
                priority if (i_byte == i_cfg.servo_type) begin
                    n_phase = tfd_pkg::PH_SERVO;
                end else if (i_byte == i_cfg.battery_type) begin
                    n_phase = tfd_pkg::PH_BATTERY;
                end else if (i_byte == i_cfg.velocity_type) begin
                    n_phase = tfd_pkg::PH_VELOCITY;
                end else begin
                    n_phase = tfd_pkg::PH_IDLE;
                end
            end
            tfd_pkg::PH_SERVO, tfd_pkg::PH_BATTERY, tfd_pkg::PH_VELOCITY: begin
                w_in_payload = 1'b1;
                if (r_count < w_need) begin
                    w_store = 1'b1;
                    n_count = r_count + 3'd1;
                end else begin
                    n_phase = tfd_pkg::PH_IDLE;
                    n_count = '0;
                end
            end
            default: begin
                n_phase = tfd_pkg::PH_IDLE;
                n_count = '0;
            end
        endcase
    end

    // outputs: result fields are built from the buffer, hit only on a good end byte
    always_comb begin
        o_hit = w_in_payload && (r_count >= w_need) && (i_byte == i_cfg.end_byte);
        unique case (r_phase)
            tfd_pkg::PH_BATTERY:  o_result.kind = tfd_pkg::KIND_BATTERY;
            tfd_pkg::PH_VELOCITY: o_result.kind = tfd_pkg::KIND_VELOCITY;
            default:              o_result.kind = tfd_pkg::KIND_SERVO;
        endcase
        o_result.first_value = {r_payload[0], r_payload[1]};
        if (r_phase == tfd_pkg::PH_SERVO) begin
            o_result.second_value = {r_payload[2], r_payload[3]};
        end else begin
            o_result.second_value = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= tfd_pkg::PH_IDLE;
            r_count <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && w_store) begin
            r_payload[r_count[1:0]] <= i_byte;
        end
    end

endmodule

// ----- sv/telemetry_frame_deframer.sv -----
// telemetry_frame_deframer: top level, input byte register, parser, result register
// depends on tfd_pkg, tfd_cfg_regs, tfd_parser
//
//  channel   direction  payload
//  s_axis    in         tdata[7:0] rx_byte
//  m_axis    out        tdata[15:0] first_value, tdata[31:16] second_value,
//                       tuser[1:0] frame_kind
//  apb       in/out     five 8-bit registers at byte addresses 0x00..0x10
//
//  one byte accepted per cycle unless a completing end byte waits on a full result register;
//  a byte sits in the input register until the parser takes it, and a frame's result
//  is loaded into the result register as its end byte is taken, then leaves from there.
//  synchronous active-low reset returns the parser to idle and empties both registers.
//  only an end byte that completes a frame waits on a full result register;
//  every other byte moves on while a result is stalled.

module telemetry_frame_deframer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // [7:0] rx_byte
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [31:0]                 m_axis_tdata,   // [15:0] first_value, [31:16] second_value
    output logic [1:0]                  m_axis_tuser,   // [1:0] frame_kind
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tfd_pkg::PADDR_W-1:0] paddr,
    input  logic [tfd_pkg::PDATA_W-1:0] pwdata,
    output logic [tfd_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    tfd_pkg::t_cfg              w_cfg;
    tfd_pkg::t_result           w_result;
    tfd_pkg::t_result           r_out;
    logic                       r_in_valid;
    logic [tfd_pkg::BYTE_W-1:0] r_in_byte;
    logic                       r_out_valid;
    logic                       w_hit;
    logic                       w_step;
    logic                       w_out_free;

    assign pready = 1'b1;

    tfd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (w_cfg)
    );

    tfd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_byte   (r_in_byte),
        .i_cfg    (w_cfg),
        .o_hit    (w_hit),
        .o_result (w_result)
    );

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_step        = r_in_valid && (!w_hit || w_out_free);
    assign s_axis_tready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_step && w_hit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
        if (w_step && w_hit) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.second_value, r_out.first_value};
    assign m_axis_tuser  = r_out.kind;

endmodule

// ----- sv/tfd_checker.sv -----
// tfd_checker: port-level assertions for telemetry_frame_deframer, bound to the top
// depends on no package; port widths are given as literals

module tfd_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [31:0]                 m_axis_tdata,
    input logic [1:0]                  m_axis_tuser
);

    // a stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // only servo frames carry a second value
    a_second_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != 2'd0) |-> m_axis_tdata[31:16] == 16'd0)
        else $error("second value set on a short frame");

    // input side only stalls behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    // reset empties the result register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind telemetry_frame_deframer tfd_checker u_tfd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- dv/telemetry_frame_checker.sv -----
`timescale 1ns / 100ps
// telemetry_frame_checker: watches the byte, result and register channels of the deframer,
// predicts decoded frames and compares them with what the block emits
// depends on tfd_pkg

module telemetry_frame_checker
    import tfd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic                i_s_tready,
    input  logic [7:0]          i_s_tdata,      // [7:0] rx_byte
    input  logic                i_m_tvalid,
    input  logic                i_m_tready,
    input  logic [31:0]         i_m_tdata,      // [15:0] first_value, [31:16] second_value
    input  logic [1:0]          i_m_tuser,      // [1:0] frame_kind
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic [PADDR_W-1:0]  i_paddr,
    input  logic [PDATA_W-1:0]  i_pwdata,
    input  logic                i_pready,
    output int                  o_fail_count,
    output int                  o_frames_pending
);

    logic [BYTE_W-1:0]  start_byte;
    logic [BYTE_W-1:0]  end_byte;
    logic [BYTE_W-1:0]  servo_type;
    logic [BYTE_W-1:0]  battery_type;
    logic [BYTE_W-1:0]  velocity_type;

    t_phase             phase;
    t_kind              frame_kind;
    logic [COUNT_W-1:0] taken;
    logic [BYTE_W-1:0]  payload [4];

    t_result            expected_frames [$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    task automatic parse_byte(input logic [BYTE_W-1:0] b);
        t_result            frame;
        logic [COUNT_W-1:0] need;
        case (phase)
            PH_IDLE: begin
                if (b == start_byte) phase = PH_TYPE;
                taken = '0;
            end
            PH_TYPE: begin
                taken = '0;
                // first match wins when type values coincide
                if (b == servo_type) begin
                    phase      = PH_SERVO;
                    frame_kind = KIND_SERVO;
                end else if (b == battery_type) begin
                    phase      = PH_BATTERY;
                    frame_kind = KIND_BATTERY;
                end else if (b == velocity_type) begin
                    phase      = PH_VELOCITY;
                    frame_kind = KIND_VELOCITY;
                end else begin
                    phase = PH_IDLE;
                end
            end
            PH_SERVO, PH_BATTERY, PH_VELOCITY: begin
                need = (phase == PH_SERVO) ? SERVO_PAYLOAD : SHORT_PAYLOAD;
                if (taken < need) begin
                    payload[taken[1:0]] = b;
                    taken = taken + 3'd1;
                end else begin
                    phase = PH_IDLE;
                    taken = '0;
                    // a bad end byte drops the frame silently
                    if (b == end_byte) begin
                        frame.kind         = frame_kind;
                        frame.first_value  = {payload[0], payload[1]};
                        frame.second_value = (frame_kind == KIND_SERVO) ?
                                             {payload[2], payload[3]} : '0;
                        expected_frames.push_back(frame);
                    end
                end
            end
            default: begin
                phase = PH_IDLE;
                taken = '0;
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            start_byte    = RST_START;
            end_byte      = RST_END;
            servo_type    = RST_SERVO;
            battery_type  = RST_BATTERY;
            velocity_type = RST_VELOCITY;
            phase         = PH_IDLE;
            frame_kind    = KIND_SERVO;
            taken         = '0;
            expected_frames.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_frames.size() == 0) begin
                    report_mismatch("result with nothing expected", i_m_tdata, '0);
                end else begin
                    want = expected_frames.pop_front();
                    if (i_m_tuser != want.kind)
                        report_mismatch("frame_kind", 32'(i_m_tuser), 32'(want.kind));
                    if (i_m_tdata[15:0] != want.first_value)
                        report_mismatch("first_value", 32'(i_m_tdata[15:0]),
                                        32'(want.first_value));
                    if (i_m_tdata[31:16] != want.second_value)
                        report_mismatch("second_value", 32'(i_m_tdata[31:16]),
                                        32'(want.second_value));
                end
            end
            if (i_s_tvalid && i_s_tready) parse_byte(i_s_tdata);
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                // only the low byte is kept; unmapped indexes are ignored
                case (i_paddr[4:2])
                    REG_START:    start_byte    = i_pwdata[7:0];
                    REG_END:      end_byte      = i_pwdata[7:0];
                    REG_SERVO:    servo_type    = i_pwdata[7:0];
                    REG_BATTERY:  battery_type  = i_pwdata[7:0];
                    REG_VELOCITY: velocity_type = i_pwdata[7:0];
                    default: ;
                endcase
            end
        end
        o_frames_pending = expected_frames.size();
    end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// tb: stimulus and verdict for telemetry_frame_deframer
// depends on tfd_pkg, telemetry_frame_deframer and telemetry_frame_checker

module tb;
    import tfd_pkg::*;

    localparam int         CYCLE_LIMIT    = 400000;
    localparam int         HOLD_CYCLES    = 400;
    localparam logic [2:0] REG_UNUSED_LO  = 3'd5;
    localparam logic [2:0] REG_UNUSED_HI  = 3'd7;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [31:0]         m_tdata;
    logic [1:0]          m_tuser;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [PDATA_W-1:0]  pwdata  = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    int                  fail_count;
    int                  frames_pending;

    int                  send_idle_pct = 20;
    int                  recv_idle_pct = 45;
    logic                hold_req      = 1'b0;
    int                  frame_bytes   = 0;

    // what the block is currently programmed with, for building frames
    logic [7:0]          cfg_start    = RST_START;
    logic [7:0]          cfg_end      = RST_END;
    logic [7:0]          cfg_servo    = RST_SERVO;
    logic [7:0]          cfg_battery  = RST_BATTERY;
    logic [7:0]          cfg_velocity = RST_VELOCITY;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    telemetry_frame_deframer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    telemetry_frame_checker frame_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_tvalid       (s_tvalid),
        .i_s_tready       (s_tready),
        .i_s_tdata        (s_tdata),
        .i_m_tvalid       (m_tvalid),
        .i_m_tready       (m_tready),
        .i_m_tdata        (m_tdata),
        .i_m_tuser        (m_tuser),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .i_pready         (pready),
        .o_fail_count     (fail_count),
        .o_frames_pending (frames_pending)
    );

    // result side backpressure, with one long hold-off when asked for
    initial begin : result_sink
        int hold_left;
        bit hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_seen) begin
                hold_seen = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        logic [PDATA_W-1:0] wdata;
        wdata      = $urandom();
        wdata[7:0] = val;
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        case (idx)
            REG_START:    cfg_start    = val;
            REG_END:      cfg_end      = val;
            REG_SERVO:    cfg_servo    = val;
            REG_BATTERY:  cfg_battery  = val;
            REG_VELOCITY: cfg_velocity = val;
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [7:0] st, input logic [7:0] en,
                                input logic [7:0] sv, input logic [7:0] bt,
                                input logic [7:0] vl);
        write_reg(REG_START, st);
        write_reg(REG_END, en);
        write_reg(REG_SERVO, sv);
        write_reg(REG_BATTERY, bt);
        write_reg(REG_VELOCITY, vl);
        write_reg(REG_UNUSED_HI, 8'($urandom_range(255)));
    endtask

    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // payload bytes go out from the low byte up
    task automatic send_frame(input t_kind kind, input logic [31:0] payload,
                              input bit good_end);
        int         n;
        logic [7:0] close;
        n = (kind == KIND_SERVO) ? int'(SERVO_PAYLOAD) : int'(SHORT_PAYLOAD);
        send_byte(cfg_start);
        case (kind)
            KIND_SERVO:   send_byte(cfg_servo);
            KIND_BATTERY: send_byte(cfg_battery);
            default:      send_byte(cfg_velocity);
        endcase
        for (int i = 0; i < n; i++) send_byte(payload[8*i +: 8]);
        close = cfg_end;
        if (!good_end) while (close == cfg_end) close = 8'($urandom_range(255));
        send_byte(close);
        frame_bytes += n + 3;
    endtask

    // mostly well-formed frames, some bad ends, broken openings and line noise
    task automatic run_random(input int target);
        int    base;
        int    pick;
        t_kind kind;
        base = frame_bytes;
        while (frame_bytes - base < target) begin
            pick = $urandom_range(99);
            kind = t_kind'($urandom_range(2));
            if (pick < 70) begin
                send_frame(kind, $urandom(), 1'b1);
            end else if (pick < 80) begin
                send_frame(kind, $urandom(), 1'b0);
            end else if (pick < 90) begin
                send_byte(cfg_start);
                send_byte(8'($urandom_range(255)));
                frame_bytes += 2;
            end else begin
                send_byte(8'($urandom_range(255)));
            end
        end
    endtask

    // let everything in flight come out before touching registers
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (frames_pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        write_reg(REG_UNUSED_LO, 8'($urandom_range(255)));

        // directed: field extremes, every kind, the special cases
        send_frame(KIND_SERVO, 32'hFF0000FF, 1'b1);
        send_frame(KIND_BATTERY, {16'h0000, cfg_end, cfg_start}, 1'b1);
        send_frame(KIND_VELOCITY, 32'h0000FFFF, 1'b1);
        send_frame(KIND_BATTERY, 32'h00001234, 1'b0);
        // unknown type byte is consumed, so the next byte is not a type
        send_byte(cfg_start);
        send_byte(cfg_start);
        send_byte(cfg_servo);

        send_idle_pct = 20;
        recv_idle_pct = 45;
        run_random(550);
        drain_results();

        program_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)));
        send_idle_pct = 45;
        recv_idle_pct = 20;
        run_random(550);
        drain_results();

        program_regs(8'h00, 8'hFF, 8'h01, 8'hFE, 8'h80);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(450);

        // receiver stalls while frames keep coming
        hold_req <= 1'b1;
        run_random(200);
        drain_results();

        // coinciding values: servo wins, then battery over velocity
        program_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        run_random(25);
        drain_results();
        program_regs(8'h00, 8'h00, 8'h5A, 8'hA5, 8'hA5);
        run_random(25);
        drain_results();

        repeat (10) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/tfd_pkg.sv
sv/tfd_cfg_regs.sv
sv/tfd_parser.sv
sv/telemetry_frame_deframer.sv
sv/tfd_checker.sv
dv/telemetry_frame_checker.sv
dv/tb.sv
